@@ rtl/core/extended_gcd_bezout_macros.svh @@
// Assertion macros for the extended GCD block.
// Used by the top level; expects clk and rst_n in the including scope.
`ifndef EXTENDED_GCD_BEZOUT_MACROS_SVH
`define EXTENDED_GCD_BEZOUT_MACROS_SVH

// Same-cycle implication, disabled in reset
`define EGCD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset
`define EGCD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/egcd_pkg.sv @@
// Shared constants and types for the extended GCD block.
// No dependencies; used by the interfaces, the divider and the top level.
`timescale 1ns / 1ps

package egcd_pkg;

  // Operand and divisor width
  localparam int OPW = 31;

  // Divider step counter width (counts OPW-1 down to 0)
  localparam int CNTW = $clog2(OPW);

  // Divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } egcd_div_stat_t;

endpackage

@@ rtl/core/egcd_if.sv @@
// Valid/ready channel interfaces for operand requests and result requests.
// Depends on egcd_pkg for the operand width.
`timescale 1ns / 1ps

interface egcd_in_if;
  logic                      valid;
  logic                      ready;
  logic [egcd_pkg::OPW-1:0]  first_value;
  logic [egcd_pkg::OPW-1:0]  second_value;

  modport source (output valid, output first_value, output second_value, input ready);
  modport sink (input valid, input first_value, input second_value, output ready);
endinterface

interface egcd_out_if #(parameter int WIDTH = 32);
  logic                      valid;
  logic                      ready;
  logic [egcd_pkg::OPW-1:0]  divisor;
  logic signed [WIDTH-1:0]   coeff_first;
  logic signed [WIDTH-1:0]   coeff_second;

  modport source (output valid, output divisor, output coeff_first, output coeff_second,
                  input ready);
  modport sink (input valid, input divisor, input coeff_first, input coeff_second,
                output ready);
endinterface

@@ rtl/core/egcd_divider.sv @@
// Radix-2 restoring divider with on-the-fly quotient products.
// Produces r0 mod r1 and q*s1, q*t1 (mod 2^WIDTH); depends on egcd_pkg.
`timescale 1ns / 1ps

module egcd_divider #(
  parameter int WIDTH = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [egcd_pkg::OPW-1:0]    dividend,
  input  logic [egcd_pkg::OPW-1:0]    divisor_in,
  input  logic [WIDTH-1:0]            mul_s,
  input  logic [WIDTH-1:0]            mul_t,
  output logic [egcd_pkg::OPW-1:0]    remainder,
  output logic [WIDTH-1:0]            prod_s,
  output logic [WIDTH-1:0]            prod_t,
  output egcd_pkg::egcd_div_stat_t    stat
);

  localparam int OPW  = egcd_pkg::OPW;
  localparam int CNTW = egcd_pkg::CNTW;

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [CNTW-1:0]      cnt_r, cnt_nxt;
  logic [OPW-1:0]       rem_r, rem_nxt;
  logic [OPW-1:0]       dvd_r, dvd_nxt;
  logic [WIDTH-1:0]     ps_r, ps_nxt;
  logic [WIDTH-1:0]     pt_r, pt_nxt;

  logic [OPW:0]         trial;
  logic [OPW:0]         diff;
  logic                 qbit;

  // One quotient bit per cycle: shift in the next dividend bit, compare, restore
  assign trial = {rem_r, dvd_r[OPW-1]};
  assign diff  = trial - {1'b0, divisor_in};
  assign qbit  = (trial >= {1'b0, divisor_in});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    ps_nxt   = ps_r;
    pt_nxt   = pt_r;
    if (start) begin
      // Load a new division
      busy_nxt = 1'b1;
      cnt_nxt  = CNTW'(OPW - 1);
      rem_nxt  = '0;
      dvd_nxt  = dividend;
      ps_nxt   = '0;
      pt_nxt   = '0;
    end else if (busy_r) begin
      // Advance one bit; accumulate products Horner-style, MSB first
      rem_nxt = qbit ? diff[OPW-1:0] : trial[OPW-1:0];
      dvd_nxt = {dvd_r[OPW-2:0], 1'b0};
      ps_nxt  = {ps_r[WIDTH-2:0], 1'b0} + (qbit ? mul_s : '0);
      pt_nxt  = {pt_r[WIDTH-2:0], 1'b0} + (qbit ? mul_t : '0);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    ps_r  <= ps_nxt;
    pt_r  <= pt_nxt;
  end

  assign remainder = rem_r;
  assign prod_s    = ps_r;
  assign prod_t    = pt_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

@@ rtl/core/extended_gcd_bezout.sv @@
// Extended GCD: one request of two 31-bit operands in, one request of
// gcd and Bezout coefficients (WIDTH-bit two's complement) out. Each
// Euclid step passes the check state and runs one division through the
// shared radix-2 divider, then rotates the remainder and coefficient
// pairs; an item takes up to about 46 Euclid steps for 31-bit operands.
// The input is not ready while an item is in progress; a finished result
// waits in the output register while the next request is accepted.
// Depends on egcd_pkg, egcd_if, egcd_divider and the assertion macros.
`timescale 1ns / 1ps
`include "extended_gcd_bezout_macros.svh"

module extended_gcd_bezout #(
  parameter int WIDTH = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  egcd_in_if.sink       in_chan,
  egcd_out_if.source    out_chan
);

  localparam int OPW = egcd_pkg::OPW;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_DONE
  } state_t;

  state_t               state_r, state_nxt;
  logic [OPW-1:0]       r0_r, r0_nxt;
  logic [OPW-1:0]       r1_r, r1_nxt;
  logic [WIDTH-1:0]     s0_r, s0_nxt;
  logic [WIDTH-1:0]     s1_r, s1_nxt;
  logic [WIDTH-1:0]     t0_r, t0_nxt;
  logic [WIDTH-1:0]     t1_r, t1_nxt;
  logic                 zero_r, zero_nxt;
  logic                 ovld_r, ovld_nxt;
  logic [OPW-1:0]       odiv_r, odiv_nxt;
  logic [WIDTH-1:0]     ocf_r, ocf_nxt;
  logic [WIDTH-1:0]     ocs_r, ocs_nxt;

  logic                 in_take;
  logic                 div_start;
  logic [OPW-1:0]       div_rem;
  logic [WIDTH-1:0]     div_ps;
  logic [WIDTH-1:0]     div_pt;
  egcd_pkg::egcd_div_stat_t div_stat;

  // Shared divider: r0 / r1 with quotient products against s1 and t1
  egcd_divider #(.WIDTH(WIDTH)) u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (div_start),
    .dividend   (r0_r),
    .divisor_in (r1_r),
    .mul_s      (s1_r),
    .mul_t      (t1_r),
    .remainder  (div_rem),
    .prod_s     (div_ps),
    .prod_t     (div_pt),
    .stat       (div_stat)
  );

  assign in_chan.ready = (state_r == ST_IDLE);
  assign in_take       = in_chan.valid && in_chan.ready;
  assign div_start     = (state_r == ST_CHECK) && (r1_r != '0);

  // Sequencer: load operands, loop divide steps until the remainder is zero
  always_comb begin
    state_nxt = state_r;
    r0_nxt    = r0_r;
    r1_nxt    = r1_r;
    s0_nxt    = s0_r;
    s1_nxt    = s1_r;
    t0_nxt    = t0_r;
    t1_nxt    = t1_r;
    zero_nxt  = zero_r;
    ovld_nxt  = ovld_r;
    odiv_nxt  = odiv_r;
    ocf_nxt   = ocf_r;
    ocs_nxt   = ocs_r;

    // Drop the result once taken
    if (out_chan.ready) begin
      ovld_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          r0_nxt    = in_chan.first_value;
          r1_nxt    = in_chan.second_value;
          s0_nxt    = WIDTH'(1);
          s1_nxt    = '0;
          t0_nxt    = '0;
          t1_nxt    = WIDTH'(1);
          zero_nxt  = (in_chan.first_value == '0) && (in_chan.second_value == '0);
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        state_nxt = (r1_r == '0) ? ST_DONE : ST_DIV;
      end
      ST_DIV: begin
        // Rotate the remainder and coefficient pairs
        if (div_stat.done) begin
          r0_nxt    = r1_r;
          r1_nxt    = div_rem;
          s0_nxt    = s1_r;
          s1_nxt    = s0_r - div_ps;
          t0_nxt    = t1_r;
          t1_nxt    = t0_r - div_pt;
          state_nxt = ST_CHECK;
        end
      end
      ST_DONE: begin
        // Hold until the output register is free
        if (!ovld_r || out_chan.ready) begin
          ovld_nxt  = 1'b1;
          odiv_nxt  = r0_r;
          ocf_nxt   = zero_r ? '0 : s0_r;
          ocs_nxt   = t0_r;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ovld_r  <= ovld_nxt;
    end
    r0_r   <= r0_nxt;
    r1_r   <= r1_nxt;
    s0_r   <= s0_nxt;
    s1_r   <= s1_nxt;
    t0_r   <= t0_nxt;
    t1_r   <= t1_nxt;
    zero_r <= zero_nxt;
    odiv_r <= odiv_nxt;
    ocf_r  <= ocf_nxt;
    ocs_r  <= ocs_nxt;
  end

  assign out_chan.valid        = ovld_r;
  assign out_chan.divisor      = odiv_r;
  assign out_chan.coeff_first  = ocf_r;
  assign out_chan.coeff_second = ocs_r;

  // Checks on the sequencer and divider handoff
  `EGCD_ASSERT_NOW(a_ready_div_idle, in_chan.ready, !div_stat.busy, "ready while divider busy")
  `EGCD_ASSERT_NOW(a_done_in_div, div_stat.done, state_r == ST_DIV, "divider done outside DIV")
  `EGCD_ASSERT_NOW(a_div_nonzero, state_r == ST_DIV, r1_r != '0, "divide by zero in DIV")
  `EGCD_ASSERT_NEXT(a_take_check, in_take, state_r == ST_CHECK, "accept did not start item")

endmodule
